@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ sv/dtasm_pkg.sv @@
// Types, constants and coefficient ROM of the dual-tone audio stats meter.
package dtasm_pkg;

    localparam int TABLE_SIZE  = 48;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int COEF_BITS   = 16;
    localparam int LANE_COUNT  = 2;
    localparam int CHAN_W      = 1;
    localparam int TONE_COUNT  = 2;
    localparam int COEF_COUNT  = 2 * TONE_COUNT;

    localparam int WORD_W      = 32;
    localparam int PAD_W       = 8;
    localparam int SAMPLE_W    = 24;
    localparam int PROD_W      = SAMPLE_W + COEF_BITS;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int LIN_W       = 41;
    localparam int TOTAL_W     = 40;
    localparam int SQ_ACC_W    = 63;
    localparam int CORR_W      = 56;
    localparam int CLIP_W      = 17;
    localparam int PAD_CNT_W   = 18;
    localparam int DISCARD_W   = 18;
    localparam int CAPTURE_W   = 17;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CAPTURE_W-1:0] CAPTURE_LIMIT = CAPTURE_W'(65536);
    localparam logic [CAPTURE_W-1:0] CAPTURE_RESET = CAPTURE_W'(48000);
    localparam logic [SAMPLE_W-1:0]  RAIL_LOW      = 24'h800000;
    localparam logic [SAMPLE_W-1:0]  RAIL_HIGH     = 24'h7FFFFF;

    typedef logic [IDX_W-1:0]            phase_t;
    typedef logic [IDX_W:0]              idx_ext_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;

    localparam idx_ext_t Q1_X = idx_ext_t'(QUARTER);
    localparam idx_ext_t Q2_X = idx_ext_t'(2 * QUARTER);
    localparam idx_ext_t Q3_X = idx_ext_t'(3 * QUARTER);
    localparam idx_ext_t Q4_X = idx_ext_t'(4 * QUARTER);
    localparam idx_ext_t TS_X = idx_ext_t'(TABLE_SIZE);

    typedef enum logic
    {
        REG_DISCARD = 1'b0,
        REG_CAPTURE = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] left_raw_word;
        logic [WORD_W-1:0] right_raw_word;
    } frame_t;

    typedef struct packed
    {
        logic                       channel_number;
        logic signed [SAMPLE_W-1:0] lowest_sample;
        logic signed [SAMPLE_W-1:0] highest_sample;
        logic [CLIP_W-1:0]          clip_count;
        logic signed [TOTAL_W-1:0]  sample_total;
        logic [SQ_ACC_W-1:0]        square_total;
        logic signed [CORR_W-1:0]   tone1_cos_total;
        logic signed [CORR_W-1:0]   tone1_sin_total;
        logic signed [CORR_W-1:0]   tone2_cos_total;
        logic signed [CORR_W-1:0]   tone2_sin_total;
        logic [PAD_CNT_W-1:0]       nonzero_pad_count;
        logic                       last_record;
    } record_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0]                low;
        logic [SAMPLE_W-1:0]                high;
        logic [CLIP_W-1:0]                  clip;
        logic [LIN_W-1:0]                   lin;
        logic [SQ_ACC_W-1:0]                sq;
        logic [COEF_COUNT-1:0][CORR_W-1:0]  corr;
    } lane_stats_t;

    function automatic coef_t quarter_cos(input logic [3:0] k);
        coef_t v;
        case (k)
            4'd0:    v = 16'sd32767;
            4'd1:    v = 16'sd32488;
            4'd2:    v = 16'sd31651;
            4'd3:    v = 16'sd30274;
            4'd4:    v = 16'sd28378;
            4'd5:    v = 16'sd25997;
            4'd6:    v = 16'sd23170;
            4'd7:    v = 16'sd19948;
            4'd8:    v = 16'sd16384;
            4'd9:    v = 16'sd12540;
            4'd10:   v = 16'sd8481;
            4'd11:   v = 16'sd4277;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic coef_t cos_at(input phase_t k);
        idx_ext_t kk;
        coef_t    v;
        kk = idx_ext_t'(k);
        if (kk <= Q1_X)
            v = quarter_cos(4'(kk));
        else if (kk <= Q2_X)
            v = -quarter_cos(4'(Q2_X - kk));
        else if (kk <= Q3_X)
            v = -quarter_cos(4'(kk - Q2_X));
        else
            v = quarter_cos(4'(Q4_X - kk));
        return v;
    endfunction

endpackage

@@ sv/dual_tone_audio_stats_meter.sv @@
// Top level of the dual-tone audio stats meter: config port, frame control, lanes.
//
// Usage:
// - frame channel (frame_valid/frame_ready/frame) carries one stereo word of two
//   left-justified 32-bit I2S words. frame_ready is always high: one frame per cycle.
// - After arming, discard_frame_count frames are dropped, then capture_frame_count
//   frames (0 read as 1, capped at 65536) are accumulated in two parallel lanes.
// - The last capture frame passes the s1, lane a_, lane done and record valid registers
//   before the left record shows on the record channel; the right record (last_record = 1)
//   follows once the left one is taken. Frames arriving after that are dropped.
// - Each lane runs a multiply stage and an accumulate stage; the 24x24 square and
//   24x16 tone products are registered in the multiply stage.
// - A stalled record channel holds the record; the accumulators are frozen meanwhile.
// - APB write at 0x0 (discard count) or 0x4 (capture count) stores the register and
//   rearms: all counters and sums clear and discarding restarts.
// - Reset loads discard 0, capture 48000 and arms the block.
`include "assert_macros.svh"

module dual_tone_audio_stats_meter
    import dtasm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_ready,
    input  frame_t            frame,
    output logic              record_valid,
    input  logic              record_ready,
    output record_t           record,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0]
    {
        MODE_DISCARDING,
        MODE_CAPTURING,
        MODE_IDLE
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [DISCARD_W-1:0]   discard_cfg_reg;
    logic [CAPTURE_W-1:0]   capture_cfg_reg;
    logic [DISCARD_W-1:0]   remaining_reg, remaining_next;
    logic [CAPTURE_W-1:0]   frames_reg, frames_next;
    phase_t                 phase_reg, phase_next;
    logic [PAD_CNT_W-1:0]   pad_reg, pad_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_first_reg, s1_first_next;
    logic                   s1_last_reg, s1_last_next;
    logic [LANE_COUNT-1:0][WORD_W-1:0]     s1_word_reg;
    logic [COEF_COUNT-1:0][COEF_BITS-1:0]  s1_coef_reg, coef_next;

    logic                   cfg_write;
    reg_index_t             cfg_index;
    logic                   accept;
    logic                   capture_go;
    logic [CAPTURE_W-1:0]   target;
    logic [CAPTURE_W-1:0]   frames_inc;
    idx_ext_t               k2_ext;
    phase_t                 k2;
    idx_ext_t               sin1_ext;
    idx_ext_t               sin2_ext;
    phase_t                 sin1;
    phase_t                 sin2;
    logic [1:0]             pad_hits;

    lane_stats_t [LANE_COUNT-1:0] stats;
    logic [LANE_COUNT-1:0]        lane_done;

    assign frame_ready = 1'b1;
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign cfg_index   = reg_index_t'(paddr[2]);
    assign accept      = frame_valid && frame_ready;

    always_comb
    begin
        case (cfg_index)
            REG_DISCARD: prdata = DATA_W'(discard_cfg_reg);
            REG_CAPTURE: prdata = DATA_W'(capture_cfg_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        if (capture_cfg_reg == '0)
            target = CAPTURE_W'(1);
        else if (capture_cfg_reg > CAPTURE_LIMIT)
            target = CAPTURE_LIMIT;
        else
            target = capture_cfg_reg;

        k2_ext   = {phase_reg, 1'b0};
        k2       = (k2_ext >= TS_X) ? IDX_W'(k2_ext - TS_X) : IDX_W'(k2_ext);
        sin1_ext = idx_ext_t'(phase_reg) + Q3_X;
        sin2_ext = idx_ext_t'(k2) + Q3_X;
        sin1     = (sin1_ext >= TS_X) ? IDX_W'(sin1_ext - TS_X) : IDX_W'(sin1_ext);
        sin2     = (sin2_ext >= TS_X) ? IDX_W'(sin2_ext - TS_X) : IDX_W'(sin2_ext);

        coef_next[0] = cos_at(phase_reg);
        coef_next[1] = cos_at(sin1);
        coef_next[2] = cos_at(k2);
        coef_next[3] = cos_at(sin2);

        frames_inc = frames_reg + CAPTURE_W'(1);
        pad_hits   = 2'(s1_word_reg[0][PAD_W-1:0] != '0)
                   + 2'(s1_word_reg[1][PAD_W-1:0] != '0);
        pad_next   = s1_valid_reg ? (pad_reg + PAD_CNT_W'(pad_hits)) : pad_reg;

        capture_go     = 1'b0;
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        frames_next    = frames_reg;
        phase_next     = phase_reg;
        s1_first_next  = 1'b0;
        s1_last_next   = 1'b0;

        if (accept)
        begin
            case (mode_reg)
                MODE_DISCARDING:
                begin
                    if (remaining_reg != '0)
                        remaining_next = remaining_reg - DISCARD_W'(1);
                    else
                        capture_go = 1'b1;
                end
                MODE_CAPTURING: capture_go = 1'b1;
                MODE_IDLE:      capture_go = 1'b0;
                default:        capture_go = 1'b0;
            endcase
        end

        if (capture_go)
        begin
            s1_first_next = (frames_reg == '0);
            s1_last_next  = (frames_inc >= target);
            frames_next   = frames_inc;
            phase_next    = (idx_ext_t'(phase_reg) == TS_X - idx_ext_t'(1)) ?
                            '0 : phase_reg + IDX_W'(1);
            mode_next     = s1_last_next ? MODE_IDLE : MODE_CAPTURING;
        end
        s1_valid_next = capture_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DISCARDING;
            discard_cfg_reg <= '0;
            capture_cfg_reg <= CAPTURE_RESET;
            remaining_reg   <= '0;
            frames_reg      <= '0;
            phase_reg       <= '0;
            pad_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s1_first_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DISCARD:
                begin
                    discard_cfg_reg <= pwdata[DISCARD_W-1:0];
                    remaining_reg   <= pwdata[DISCARD_W-1:0];
                end
                REG_CAPTURE:
                begin
                    capture_cfg_reg <= pwdata[CAPTURE_W-1:0];
                    remaining_reg   <= discard_cfg_reg;
                end
                default:
                begin
                    remaining_reg <= discard_cfg_reg;
                end
            endcase
            mode_reg     <= MODE_DISCARDING;
            frames_reg   <= '0;
            phase_reg    <= '0;
            pad_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
            frames_reg    <= frames_next;
            phase_reg     <= phase_next;
            pad_reg       <= pad_next;
            s1_valid_reg  <= s1_valid_next;
            s1_first_reg  <= s1_first_next;
            s1_last_reg   <= s1_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg[0] <= frame.left_raw_word;
        s1_word_reg[1] <= frame.right_raw_word;
        s1_coef_reg    <= coef_next;
    end

    for (genvar c = 0; c < LANE_COUNT; c++)
    begin : g_lane
        dtasm_lane u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (cfg_write),
            .in_valid (s1_valid_reg),
            .in_first (s1_first_reg),
            .in_last  (s1_last_reg),
            .raw_word (s1_word_reg[c]),
            .coef     (s1_coef_reg),
            .stats    (stats[c]),
            .done     (lane_done[c])
        );
    end

    dtasm_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_write),
        .done         (lane_done[0]),
        .stats        (stats),
        .pad_count    (pad_reg),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record       (record)
    );

    `ASSERT_IMP(record_only_when_idle, clk, rst_n, record_valid, mode_reg == MODE_IDLE)
    `ASSERT_IMP(lanes_in_step, clk, rst_n, lane_done[0], lane_done[LANE_COUNT-1])

endmodule

@@ sv/dtasm_lane.sv @@
// One channel lane: sample decode, multiply stage and accumulate stage.
`include "assert_macros.svh"

module dtasm_lane
    import dtasm_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  logic                               in_valid,
    input  logic                               in_first,
    input  logic                               in_last,
    input  logic [WORD_W-1:0]                  raw_word,
    input  logic [COEF_COUNT-1:0][COEF_BITS-1:0] coef,
    output lane_stats_t                        stats,
    output logic                               done
);

    logic signed [SAMPLE_W-1:0]          sample_next;
    logic [SQ_W-1:0]                     sq_next;
    logic [COEF_COUNT-1:0][PROD_W-1:0]   prod_next;
    logic                                clip_next;

    logic                                a_valid_reg;
    logic                                a_first_reg;
    logic                                a_last_reg;
    logic signed [SAMPLE_W-1:0]          a_sample_reg;
    logic [SQ_W-1:0]                     a_sq_reg;
    logic [COEF_COUNT-1:0][PROD_W-1:0]   a_prod_reg;
    logic                                a_clip_reg;

    logic signed [SAMPLE_W-1:0]          low_reg;
    logic signed [SAMPLE_W-1:0]          high_reg;
    logic [CLIP_W-1:0]                   clip_reg;
    logic signed [LIN_W-1:0]             lin_reg;
    logic [SQ_ACC_W-1:0]                 sq_reg;
    logic [COEF_COUNT-1:0][CORR_W-1:0]   corr_reg;
    logic                                done_reg;

    always_comb
    begin
        sample_next = $signed(raw_word[WORD_W-1:PAD_W]);
        sq_next     = SQ_W'(sample_next) * SQ_W'(sample_next);
        clip_next   = (sample_next == RAIL_LOW) || (sample_next == RAIL_HIGH);
        for (int j = 0; j < COEF_COUNT; j++)
        begin
            prod_next[j] = PROD_W'(sample_next) * PROD_W'($signed(coef[j]));
        end
    end

    always_ff @(posedge clk)
    begin
        a_sample_reg <= sample_next;
        a_sq_reg     <= sq_next;
        a_prod_reg   <= prod_next;
        a_clip_reg   <= clip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_first_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '0;
            clip_reg    <= '0;
            lin_reg     <= '0;
            sq_reg      <= '0;
            corr_reg    <= '0;
        end
        else if (clear)
        begin
            a_valid_reg <= 1'b0;
            a_first_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '0;
            clip_reg    <= '0;
            lin_reg     <= '0;
            sq_reg      <= '0;
            corr_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            a_first_reg <= in_first;
            a_last_reg  <= in_last;
            done_reg    <= a_valid_reg && a_last_reg;
            if (a_valid_reg)
            begin
                if (a_first_reg || (a_sample_reg < low_reg))
                    low_reg <= a_sample_reg;
                if (a_first_reg || (a_sample_reg > high_reg))
                    high_reg <= a_sample_reg;
                clip_reg <= clip_reg + CLIP_W'(a_clip_reg);
                lin_reg  <= lin_reg + LIN_W'(a_sample_reg);
                sq_reg   <= sq_reg + SQ_ACC_W'(a_sq_reg);
                for (int j = 0; j < COEF_COUNT; j++)
                begin
                    corr_reg[j] <= corr_reg[j] + CORR_W'($signed(a_prod_reg[j]));
                end
            end
        end
    end

    always_comb
    begin
        stats.low  = low_reg;
        stats.high = high_reg;
        stats.clip = clip_reg;
        stats.lin  = lin_reg;
        stats.sq   = sq_reg;
        stats.corr = corr_reg;
    end

    assign done = done_reg;

    `ASSERT_NXT(a_first_sets_range, clk, rst_n,
        a_valid_reg && a_first_reg && !clear, low_reg == high_reg)

endmodule

@@ sv/dtasm_merge.sv @@
// Record stage: walks the lanes and presents one record word per channel.
`include "assert_macros.svh"

module dtasm_merge
    import dtasm_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic                             done,
    input  lane_stats_t [LANE_COUNT-1:0]     stats,
    input  logic [PAD_CNT_W-1:0]             pad_count,
    output logic                             record_valid,
    input  logic                             record_ready,
    output record_t                          record
);

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(LANE_COUNT - 1);

    logic              valid_reg;
    logic [CHAN_W-1:0] chan_reg;
    lane_stats_t       sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            chan_reg  <= '0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
            chan_reg  <= '0;
        end
        else if (done)
        begin
            valid_reg <= 1'b1;
            chan_reg  <= '0;
        end
        else if (valid_reg && record_ready)
        begin
            if (chan_reg == LAST_CHAN)
            begin
                valid_reg <= 1'b0;
                chan_reg  <= '0;
            end
            else
            begin
                chan_reg <= chan_reg + CHAN_W'(1);
            end
        end
    end

    always_comb
    begin
        sel                      = stats[chan_reg];
        record.channel_number    = chan_reg;
        record.lowest_sample     = sel.low;
        record.highest_sample    = sel.high;
        record.clip_count        = sel.clip;
        record.sample_total      = sel.lin[TOTAL_W-1:0];
        record.square_total      = sel.sq;
        record.tone1_cos_total   = sel.corr[0];
        record.tone1_sin_total   = sel.corr[1];
        record.tone2_cos_total   = sel.corr[2];
        record.tone2_sin_total   = sel.corr[3];
        record.nonzero_pad_count = pad_count;
        record.last_record       = (chan_reg == LAST_CHAN);
    end

    assign record_valid = valid_reg;

    `ASSERT_IMP(done_only_when_empty, clk, rst_n, done, !valid_reg)
    `ASSERT_NXT(done_starts_left, clk, rst_n, done && !clear,
        valid_reg && (chan_reg == '0))

endmodule
